>>> hdl/lbsp_pkg.sv
// Shared types and constants for the lock board serial protocol core.
`timescale 1ns / 1ps
package lbsp_pkg;

  typedef enum logic [1:0] {
    FUNC_UNLOCK = 2'd0,
    FUNC_POLL   = 2'd1,
    FUNC_RX     = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    KIND_TX        = 2'd0,
    KIND_LOCKED    = 2'd1,
    KIND_POLL_WAIT = 2'd2
  } kind_e;

  typedef struct packed {
    func_e      func;
    logic [7:0] rx_byte;
    logic       rx_last;
  } in_req_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] tx_byte;
    logic       last;
  } out_rsp_t;

  // one pending output job: a whole command frame or a single signal
  typedef struct packed {
    logic       frame;
    kind_e      kind;
    logic [7:0] cmd;
  } job_t;

  localparam int unsigned HeadLen = 5;
  localparam logic [7:0] FRAME_HEAD [HeadLen] = '{8'h57, 8'h4B, 8'h4C, 8'h59, 8'h09};
  localparam logic [3:0] FrameLastIdx = 4'd8;

endpackage

>>> hdl/lock_board_serial_protocol_core.sv
// Top level of the lock board serial protocol core.
// Usage:
//   in channel  (in_valid_i/in_ready_o/in_req_i): unlock request, poll request,
//     or one response byte with a last-of-chunk flag.
//   out channel (out_valid_o/out_ready_i/out_rsp_o): frame bytes, a locked
//     report, or a start-poll-wait signal; last marks the end of one request's
//     results.
//   cfg port: cfg_we_i writes board, channel, unlock code or status code;
//     write only while the core is idle.
// Each request is decoded in the cycle it is accepted; chunk state and phase
// update at that edge. A result-producing request lands in a one-entry job
// register; with the serializer free, it moves on into the serializer's
// registers and its first result is then on the port. A frame is nine bytes,
// a signal a single result. Any request is taken while the job register is
// free or draining, so requests follow back to back while output flows.
// Reset: phase idle, chunk cleared, registers to their defaults, output empty.
// Output stall: the current result holds; once the job register is full,
// in_ready_o drops until the serializer frees it.
`timescale 1ns / 1ps
module lock_board_serial_protocol_core import lbsp_pkg::*; #(
  parameter int unsigned MAX_RESPONSE = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_req_t    in_req_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_rsp_t   out_rsp_o
);

  localparam int unsigned CntW = $clog2(MAX_RESPONSE + 2);
  localparam logic [CntW-1:0] CntSat = CntW'(MAX_RESPONSE + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_RESPONSE);
  localparam logic [CntW-1:0] CntMin = CntW'(10);

  localparam logic [1:0] REG_BOARD   = 2'd0;
  localparam logic [1:0] REG_CHANNEL = 2'd1;
  localparam logic [1:0] REG_UNLOCK  = 2'd2;
  localparam logic [1:0] REG_STATUS  = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_UNLOCKING = 2'd1,
    PH_WAITING   = 2'd2,
    PH_POLLING   = 2'd3
  } phase_e;

  logic [7:0] board_q, channel_q, unlock_q, status_q;

  phase_e          phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_n;
  logic [7:0]      chk_q, chk_d, chk_n;
  logic            hdr_q, hdr_d, hdr_n;
  logic [7:0]      gboard_q, gboard_d, gboard_n;
  logic [7:0]      gcmd_q, gcmd_d, gcmd_n;
  logic [7:0]      gstat_q, gstat_d, gstat_n;
  logic [7:0]      gchan_q, gchan_d, gchan_n;
  logic [7:0]      glock_q, glock_d, glock_n;

  job_t job_q, job_d, job_new;
  logic job_vld_q, job_vld_d, job_set;
  logic tx_ready;
  logic in_fire;
  logic ok;

  assign in_ready_o = !job_vld_q || tx_ready;
  assign in_fire    = in_valid_i && in_ready_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      board_q   <= 8'd1;
      channel_q <= 8'd1;
      unlock_q  <= 8'd0;
      status_q  <= 8'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BOARD:   board_q   <= cfg_wdata_i;
        REG_CHANNEL: channel_q <= cfg_wdata_i;
        REG_UNLOCK:  unlock_q  <= cfg_wdata_i;
        REG_STATUS:  status_q  <= cfg_wdata_i;
        default:     board_q   <= board_q;
      endcase
    end
  end

  // chunk bookkeeping with the incoming byte folded in
  always_comb begin
    hdr_n    = hdr_q;
    if (cnt_q < CntW'(4) && in_req_i.rx_byte != FRAME_HEAD[cnt_q[2:0]]) begin
      hdr_n = 1'b0;
    end
    chk_n    = chk_q ^ in_req_i.rx_byte;
    gboard_n = (cnt_q == CntW'(5)) ? in_req_i.rx_byte : gboard_q;
    gcmd_n   = (cnt_q == CntW'(6)) ? in_req_i.rx_byte : gcmd_q;
    gstat_n  = (cnt_q == CntW'(7)) ? in_req_i.rx_byte : gstat_q;
    gchan_n  = (cnt_q == CntW'(8)) ? in_req_i.rx_byte : gchan_q;
    glock_n  = (cnt_q == CntW'(9)) ? in_req_i.rx_byte : glock_q;
    cnt_n    = (cnt_q < CntSat) ? cnt_q + CntW'(1) : cnt_q;
  end

  // response check; the command byte is ignored in waiting and idle phases
  always_comb begin
    ok = hdr_n && (chk_n == 8'h00) && (cnt_n >= CntMin) && (cnt_n <= CntMax) &&
         (gboard_n == board_q) && (gchan_n == channel_q) &&
         (gstat_n == 8'h00) && (glock_n <= 8'd1);
    if (phase_q == PH_UNLOCKING && gcmd_n != unlock_q) ok = 1'b0;
    if (phase_q == PH_POLLING && gcmd_n != status_q) ok = 1'b0;
  end

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    chk_d    = chk_q;
    hdr_d    = hdr_q;
    gboard_d = gboard_q;
    gcmd_d   = gcmd_q;
    gstat_d  = gstat_q;
    gchan_d  = gchan_q;
    glock_d  = glock_q;
    job_set  = 1'b0;
    job_new  = '{frame: 1'b1, kind: KIND_TX, cmd: status_q};

    if (in_fire) begin
      unique case (in_req_i.func)
        FUNC_UNLOCK, FUNC_POLL: begin
          cnt_d = '0; chk_d = '0; hdr_d = 1'b1;
          gboard_d = '0; gcmd_d = '0; gstat_d = '0; gchan_d = '0; glock_d = '0;
          job_set = 1'b1;
          if (in_req_i.func == FUNC_UNLOCK) begin
            phase_d     = PH_UNLOCKING;
            job_new.cmd = unlock_q;
          end else begin
            phase_d = PH_POLLING;
          end
        end
        FUNC_RX: begin
          if (!in_req_i.rx_last) begin
            cnt_d = cnt_n; chk_d = chk_n; hdr_d = hdr_n;
            gboard_d = gboard_n; gcmd_d = gcmd_n; gstat_d = gstat_n;
            gchan_d = gchan_n; glock_d = glock_n;
          end else begin
            cnt_d = '0; chk_d = '0; hdr_d = 1'b1;
            gboard_d = '0; gcmd_d = '0; gstat_d = '0; gchan_d = '0; glock_d = '0;
            if (!ok) begin
              // resend the command of the current phase
              job_set = (phase_q != PH_IDLE);
              if (phase_q == PH_UNLOCKING) job_new.cmd = unlock_q;
            end else if (glock_n == 8'd0) begin
              if (phase_q == PH_UNLOCKING || phase_q == PH_WAITING) begin
                phase_d = PH_POLLING;
                job_set = 1'b1;
              end else if (phase_q == PH_POLLING) begin
                job_set = 1'b1;
                job_new = '{frame: 1'b0, kind: KIND_POLL_WAIT, cmd: 8'h00};
              end
            end else begin
              if (phase_q == PH_UNLOCKING || phase_q == PH_WAITING) begin
                phase_d = PH_WAITING;
                job_set = 1'b1;
              end else if (phase_q == PH_POLLING) begin
                phase_d = PH_IDLE;
                job_set = 1'b1;
                job_new = '{frame: 1'b0, kind: KIND_LOCKED, cmd: 8'h00};
              end
            end
          end
        end
        default: phase_d = phase_q;
      endcase
    end
  end

  // one-entry job register in front of the serializer
  always_comb begin
    job_vld_d = job_vld_q && !tx_ready;
    job_d     = job_q;
    if (job_set) begin
      job_vld_d = 1'b1;
      job_d     = job_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      cnt_q     <= '0;
      chk_q     <= '0;
      hdr_q     <= 1'b1;
      gboard_q  <= '0;
      gcmd_q    <= '0;
      gstat_q   <= '0;
      gchan_q   <= '0;
      glock_q   <= '0;
      job_vld_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      chk_q     <= chk_d;
      hdr_q     <= hdr_d;
      gboard_q  <= gboard_d;
      gcmd_q    <= gcmd_d;
      gstat_q   <= gstat_d;
      gchan_q   <= gchan_d;
      glock_q   <= glock_d;
      job_vld_q <= job_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  lbsp_tx u_tx (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .board_id_i   (board_q),
    .channel_id_i (channel_q),
    .job_valid_i  (job_vld_q),
    .job_ready_o  (tx_ready),
    .job_i        (job_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_rsp_o    (out_rsp_o)
  );

endmodule

>>> hdl/lbsp_tx.sv
// Output serializer: turns queued jobs into frame bytes or single signals.
`timescale 1ns / 1ps
module lbsp_tx import lbsp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] board_id_i,
  input  logic [7:0] channel_id_i,
  input  logic       job_valid_i,
  output logic       job_ready_o,
  input  job_t       job_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_rsp_t   out_rsp_o
);

  logic       busy_q;
  logic [3:0] idx_q;
  logic       frame_q;
  kind_e      kind_q;
  logic [7:0] cmd_q;
  logic       last_beat;
  logic [7:0] frame_byte;

  assign last_beat   = !frame_q || (idx_q == FrameLastIdx);
  assign job_ready_o = !busy_q || (out_ready_i && last_beat);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      idx_q   <= '0;
      frame_q <= 1'b0;
      kind_q  <= KIND_TX;
      cmd_q   <= '0;
    end else if (job_valid_i && job_ready_o) begin
      busy_q  <= 1'b1;
      idx_q   <= '0;
      frame_q <= job_i.frame;
      kind_q  <= job_i.kind;
      cmd_q   <= job_i.cmd;
    end else if (busy_q && out_ready_i) begin
      if (last_beat) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 4'd1;
      end
    end
  end

  // header xor folds to zero, so the check byte is board ^ cmd ^ channel
  always_comb begin
    unique case (idx_q)
      4'd0, 4'd1, 4'd2, 4'd3, 4'd4: frame_byte = FRAME_HEAD[idx_q[2:0]];
      4'd5:    frame_byte = board_id_i;
      4'd6:    frame_byte = cmd_q;
      4'd7:    frame_byte = channel_id_i;
      4'd8:    frame_byte = board_id_i ^ cmd_q ^ channel_id_i;
      default: frame_byte = 8'h00;
    endcase
  end

  assign out_valid_o       = busy_q;
  assign out_rsp_o.kind    = frame_q ? KIND_TX : kind_q;
  assign out_rsp_o.tx_byte = frame_q ? frame_byte : 8'h00;
  assign out_rsp_o.last    = last_beat;

endmodule

>>> hdl/lbsp_checker.sv
// Port-level checks for the lock board serial protocol core, bound to the top.
`timescale 1ns / 1ps
module lbsp_checker import lbsp_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input out_rsp_t out_rsp_o
);

  // signal results are single and carry no byte
  a_signal_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.kind != KIND_TX |-> out_rsp_o.last && out_rsp_o.tx_byte == 8'h00)
    else $error("signal result not single or carries a byte");

  // a frame streams without gaps once started
  a_frame_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_rsp_o.kind == KIND_TX && !out_rsp_o.last
    |=> out_valid_o && out_rsp_o.kind == KIND_TX)
    else $error("frame interrupted");

  // a frame that directly follows a finished request opens with the header
  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_rsp_o.last
    |=> !out_valid_o || out_rsp_o.kind != KIND_TX || out_rsp_o.tx_byte == 8'h57)
    else $error("frame does not start with the header");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("output request changed while stalled");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind lock_board_serial_protocol_core lbsp_checker u_lbsp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);

>>> tb/sv/tb.sv
// Testbench for the lock board serial protocol core: frame, resend and phase checks.
`timescale 1ns / 1ps
module tb;
  import lbsp_pkg::*;

  localparam int MAX_RESP = 32;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [39:0] FRAME_HDR = 40'h574B4C5909;

  localparam logic [1:0] REG_BOARD   = 2'd0;
  localparam logic [1:0] REG_CHANNEL = 2'd1;
  localparam logic [1:0] REG_UNLOCK  = 2'd2;
  localparam logic [1:0] REG_STATUS  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_UNLOCK = 2'd1,
    ST_WAIT   = 2'd2,
    ST_POLL   = 2'd3
  } lock_phase_e;

  typedef enum logic [1:0] {
    FLT_NONE,
    FLT_HEAD,
    FLT_XOR
  } chunk_fault_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [7:0] cfg_wdata_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  in_req_t    in_req_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_rsp_t   out_rsp_o;

  always #5 clk_i = ~clk_i;

  lock_board_serial_protocol_core #(
    .MAX_RESPONSE(MAX_RESP)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  // shadow registers and protocol state
  logic [7:0]  cfg_board, cfg_chan, cfg_unlock, cfg_status;
  lock_phase_e st;
  logic [6:0]  chunk_len;
  logic [7:0]  chunk_xor;
  logic        head_ok;
  logic [7:0]  rb_board, rb_cmd, rb_status, rb_chan, rb_lock;

  out_rsp_t board_rsp_q[$];
  out_rsp_t want_rsp;
  int       errors = 0;
  int       items_sent = 0;
  int       idle_pct = 0;
  int       stall_pct = 0;
  int       quiet_cycles = 0;

  function automatic logic [7:0] hdr_byte(int i);
    return FRAME_HDR[39-8*i -: 8];
  endfunction

  function automatic void clear_chunk();
    chunk_len = '0;
    chunk_xor = '0;
    head_ok   = 1'b1;
    rb_board  = '0;
    rb_cmd    = '0;
    rb_status = '0;
    rb_chan   = '0;
    rb_lock   = '0;
  endfunction

  function automatic void reset_lock_state();
    cfg_board  = 8'd1;
    cfg_chan   = 8'd1;
    cfg_unlock = 8'd0;
    cfg_status = 8'd1;
    st         = ST_IDLE;
    clear_chunk();
  endfunction

  function automatic void push_frame(logic [7:0] cmd);
    out_rsp_t   e;
    logic [7:0] b;
    logic [7:0] chk;
    chk = '0;
    for (int i = 0; i < 9; i++) begin
      if (i < 5) b = hdr_byte(i);
      else if (i == 5) b = cfg_board;
      else if (i == 6) b = cmd;
      else if (i == 7) b = cfg_chan;
      else b = chk;
      chk ^= b;
      e.kind    = KIND_TX;
      e.tx_byte = b;
      e.last    = (i == 8);
      board_rsp_q.push_back(e);
    end
  endfunction

  function automatic void push_signal(kind_e k);
    out_rsp_t e;
    e.kind    = k;
    e.tx_byte = '0;
    e.last    = 1'b1;
    board_rsp_q.push_back(e);
  endfunction

  function automatic void judge_chunk();
    logic ok;
    ok = head_ok && chunk_xor == 8'd0 && chunk_len >= 7'd10 && chunk_len <= 7'(MAX_RESP);
    if (ok && (rb_board != cfg_board || rb_chan != cfg_chan)) ok = 1'b0;
    if (ok && st == ST_UNLOCK && rb_cmd != cfg_unlock) ok = 1'b0;
    if (ok && st == ST_POLL && rb_cmd != cfg_status) ok = 1'b0;
    if (ok && rb_status != 8'd0) ok = 1'b0;
    if (ok && rb_lock > 8'd1) ok = 1'b0;
    if (!ok) begin
      if (st == ST_UNLOCK) push_frame(cfg_unlock);
      else if (st != ST_IDLE) push_frame(cfg_status);
    end else if (rb_lock == 8'd0) begin
      if (st == ST_UNLOCK || st == ST_WAIT) begin
        st = ST_POLL;
        push_frame(cfg_status);
      end else if (st == ST_POLL) begin
        push_signal(KIND_POLL_WAIT);
      end
    end else begin
      if (st == ST_UNLOCK || st == ST_WAIT) begin
        st = ST_WAIT;
        push_frame(cfg_status);
      end else if (st == ST_POLL) begin
        st = ST_IDLE;
        push_signal(KIND_LOCKED);
      end
    end
  endfunction

  function automatic void predict_lock_board(in_req_t r);
    logic [6:0] pos;
    pos = chunk_len;
    case (r.func)
      FUNC_UNLOCK: begin
        clear_chunk();
        st = ST_UNLOCK;
        push_frame(cfg_unlock);
      end
      FUNC_POLL: begin
        clear_chunk();
        st = ST_POLL;
        push_frame(cfg_status);
      end
      FUNC_RX: begin
        if (pos < 7'd4 && r.rx_byte != hdr_byte(int'(pos))) head_ok = 1'b0;
        chunk_xor ^= r.rx_byte;
        case (pos)
          7'd5: rb_board = r.rx_byte;
          7'd6: rb_cmd = r.rx_byte;
          7'd7: rb_status = r.rx_byte;
          7'd8: rb_chan = r.rx_byte;
          7'd9: rb_lock = r.rx_byte;
          default: ;
        endcase
        if (chunk_len < 7'(MAX_RESP + 1)) chunk_len++;
        if (r.rx_last) begin
          judge_chunk();
          clear_chunk();
        end
      end
      default: ;
    endcase
  endfunction

  // one request; valid stays up if the next one follows without a gap
  task automatic send_req(in_req_t r);
    int gap;
    gap = 0;
    while (gap < 100 && $urandom_range(99) < idle_pct) gap++;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    items_sent++;
    predict_lock_board(r);
  endtask

  task automatic send_op(func_e f);
    in_req_t r;
    r.func    = f;
    r.rx_byte = 8'($urandom_range(255));
    r.rx_last = 1'($urandom_range(1));
    send_req(r);
  endtask

  // byte 4 is unchecked, so it balances the XOR of the whole chunk
  task automatic send_chunk(input logic [7:0] board, input logic [7:0] cmd,
                            input logic [7:0] status, input logic [7:0] chan,
                            input logic [7:0] lock, input int len,
                            input chunk_fault_e fault, input int cut);
    logic [7:0] cb [64];
    logic [7:0] x;
    int         span, n, k;
    in_req_t    r;
    span = (len < 10) ? 10 : len;
    for (int i = 0; i < 4; i++) cb[i] = hdr_byte(i);
    cb[5] = board;
    cb[6] = cmd;
    cb[7] = status;
    cb[8] = chan;
    cb[9] = lock;
    for (int i = 10; i < span; i++) cb[i] = 8'($urandom_range(255));
    x = '0;
    for (int i = 0; i < span; i++) if (i != 4) x ^= cb[i];
    cb[4] = x;
    if (fault == FLT_HEAD) begin
      k = $urandom_range(3);
      cb[k] = cb[k] ^ (8'h01 << $urandom_range(7));
    end else if (fault == FLT_XOR) begin
      cb[4] = cb[4] ^ 8'($urandom_range(1, 255));
    end
    n = (cut > 0) ? cut : len;
    for (int i = 0; i < n; i++) begin
      r.func    = FUNC_RX;
      r.rx_byte = cb[i];
      r.rx_last = (cut == 0 && i == n - 1);
      send_req(r);
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board_rsp_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic put_reg(logic [1:0] idx, logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_BOARD:   cfg_board = val;
      REG_CHANNEL: cfg_chan = val;
      REG_UNLOCK:  cfg_unlock = val;
      REG_STATUS:  cfg_status = val;
      default: ;
    endcase
  endtask

  // only called with the core drained
  task automatic write_config(logic [7:0] board, logic [7:0] chan,
                              logic [7:0] unl, logic [7:0] stat);
    put_reg(REG_BOARD, board);
    put_reg(REG_CHANNEL, chan);
    put_reg(REG_UNLOCK, unl);
    put_reg(REG_STATUS, stat);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_idle_and_requests();
    send_chunk(cfg_board, cfg_status, 8'h00, cfg_chan, 8'h00, 10, FLT_NONE, 0);
    send_op(func_e'(2'd3));
    send_op(FUNC_UNLOCK);
    send_op(FUNC_POLL);
  endtask

  task automatic test_unlock_to_locked();
    drain_results();
    write_config(8'h00, 8'h00, 8'h00, 8'hFF);
    send_op(FUNC_UNLOCK);
    send_chunk(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 10, FLT_NONE, 0);
    // waiting phase ignores the command byte
    send_chunk(8'h00, 8'h33, 8'h00, 8'h00, 8'h01, 10, FLT_NONE, 0);
    send_chunk(8'h00, 8'hC3, 8'h00, 8'h00, 8'h00, MAX_RESP, FLT_NONE, 0);
    send_chunk(8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 10, FLT_NONE, 0);
    send_op(FUNC_POLL);
    send_chunk(8'h00, 8'hFF, 8'h00, 8'h00, 8'h01, 10, FLT_NONE, 0);
  endtask

  task automatic test_failed_checks();
    drain_results();
    write_config(8'hFF, 8'hFF, 8'hFF, 8'h00);
    send_op(FUNC_POLL);
    send_chunk(8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 9, FLT_NONE, 0);
    send_chunk(8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, MAX_RESP + 1, FLT_NONE, 0);
    send_chunk(8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 10, FLT_HEAD, 0);
    send_chunk(8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 10, FLT_XOR, 0);
    send_chunk(8'hFE, 8'h00, 8'h00, 8'hFF, 8'h00, 10, FLT_NONE, 0);
    send_chunk(8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 10, FLT_NONE, 0);
    send_chunk(8'hFF, 8'h00, 8'h01, 8'hFF, 8'h00, 10, FLT_NONE, 0);
    send_chunk(8'hFF, 8'h00, 8'h00, 8'hFF, 8'h02, 10, FLT_NONE, 0);
    // request in the middle of a chunk drops it
    send_chunk(8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 10, FLT_NONE, 6);
    send_op(FUNC_POLL);
    send_chunk(8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 10, FLT_NONE, 0);
  endtask

  task automatic random_chunk(int cut);
    logic [7:0]   board, cmd, status, chan, lock;
    int           len, sel;
    chunk_fault_e fault;
    board  = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : cfg_board;
    chan   = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : cfg_chan;
    cmd    = (st == ST_UNLOCK) ? cfg_unlock : cfg_status;
    if ($urandom_range(7) == 0) cmd = 8'($urandom_range(255));
    status = ($urandom_range(11) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
    sel = $urandom_range(19);
    if (sel < 9) lock = 8'h00;
    else if (sel < 18) lock = 8'h01;
    else lock = 8'($urandom_range(2, 255));
    sel = $urandom_range(19);
    if (sel < 14) len = $urandom_range(10, 13);
    else if (sel < 17) len = $urandom_range(14, MAX_RESP);
    else if (sel == 17) len = MAX_RESP;
    else if (sel == 18) len = $urandom_range(MAX_RESP + 1, 40);
    else len = $urandom_range(1, 9);
    sel = $urandom_range(19);
    fault = (sel == 0) ? FLT_HEAD : (sel == 1) ? FLT_XOR : FLT_NONE;
    send_chunk(board, cmd, status, chan, lock, len, fault, cut);
  endtask

  task automatic run_phase(int idle, int stall, logic [7:0] board, logic [7:0] chan,
                           logic [7:0] unl, logic [7:0] stat, int n_items);
    int      target, sel;
    in_req_t r;
    drain_results();
    write_config(board, chan, unl, stat);
    idle_pct  = idle;
    stall_pct = stall;
    target = items_sent + n_items;
    while (items_sent < target) begin
      sel = $urandom_range(99);
      if (sel < 6) begin
        r.func    = FUNC_RX;
        r.rx_byte = 8'($urandom_range(255));
        r.rx_last = 1'($urandom_range(1));
        send_req(r);
      end else if (sel < 9) begin
        send_op(func_e'(2'd3));
      end else if (sel < 17) begin
        send_op($urandom_range(1) ? FUNC_POLL : FUNC_UNLOCK);
      end else if (sel < 22) begin
        random_chunk($urandom_range(1, 9));
        send_op($urandom_range(1) ? FUNC_POLL : FUNC_UNLOCK);
      end else if (sel < 24) begin
        drain_results();
      end else begin
        random_chunk(0);
      end
    end
  endtask

  task automatic test_random_traffic();
    run_phase(0, 0, 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)), 8'($urandom_range(255)), 3);
    run_phase(85, 0, 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)), 8'($urandom_range(255)), 3);
    run_phase(0, 85, 8'h01, 8'h01, 8'h00, 8'h01, 3);
    run_phase(31, 31, 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)), 8'($urandom_range(255)), 3);
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (board_rsp_q.size() == 0) begin
        $error("unexpected result: kind %0d tx_byte %02h last %0d",
               out_rsp_o.kind, out_rsp_o.tx_byte, out_rsp_o.last);
        errors++;
      end else begin
        want_rsp = board_rsp_q.pop_front();
        if (out_rsp_o.kind !== want_rsp.kind) begin
          $error("kind: expected %0d, got %0d", want_rsp.kind, out_rsp_o.kind);
          errors++;
        end
        if (out_rsp_o.tx_byte !== want_rsp.tx_byte) begin
          $error("tx_byte: expected %02h, got %02h", want_rsp.tx_byte, out_rsp_o.tx_byte);
          errors++;
        end
        if (out_rsp_o.last !== want_rsp.last) begin
          $error("last: expected %0d, got %0d", want_rsp.last, out_rsp_o.last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o === 1'b1) || (out_valid_o === 1'b1 && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    reset_lock_state();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_idle_and_requests();
    test_unlock_to_locked();
    test_failed_checks();
    test_random_traffic();
    drain_results();
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
